@@ src/pmmu_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged MMU package
// Request and response types, register indexes and constants shared by the
// MMU modules.
// ----------------------------------------------------------------------------
package pmmu_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd3;

    localparam logic [4:0]  RST_PAGE_SHIFT = 5'd12;
    localparam logic [8:0]  RST_NUM_PAGES  = 9'd256;
    localparam logic [6:0]  RST_NUM_FRAMES = 7'd64;
    localparam logic [15:0] RST_SEED       = 16'd1;
    localparam logic [15:0] LFSR_TAPS      = 16'hB400;

    typedef struct packed {
        logic        op;
        logic [31:0] vaddr;
    } t_req;

    typedef struct packed {
        logic [31:0] phys_addr;
        logic        illegal;
        logic        pg_fault;
        logic        write_back;
        logic        evicted_valid;
        logic [7:0]  evicted_page;
    } t_rsp;

    typedef struct packed {
        logic        load;
        logic [15:0] seed;
        logic        step;
        logic [6:0]  num_frames;
    } t_victim_ctl;

endpackage

@@ src/pmmu_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pmmu_victim.sv @@
// ----------------------------------------------------------------------------
// Victim frame selector
// Galois LFSR that steps once per eviction and scales its value onto the
// number of frames in use.
// ----------------------------------------------------------------------------
module pmmu_victim #(
    parameter int MAX_FRAMES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmmu_pkg::t_victim_ctl         i_ctl,
    output logic [$clog2(MAX_FRAMES)-1:0] o_frame
);

    localparam int FW = $clog2(MAX_FRAMES);

    logic [15:0] r_lfsr;
    logic [15:0] n_lfsr;
    logic [22:0] w_prod;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_ctl.load) begin
            n_lfsr = (i_ctl.seed == 16'd0) ? 16'd1 : i_ctl.seed;
        end else if (i_ctl.step) begin
            n_lfsr = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? pmmu_pkg::LFSR_TAPS : 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= pmmu_pkg::RST_SEED;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

    assign w_prod  = 23'(r_lfsr) * 23'(i_ctl.num_frames);
    assign o_frame = FW'(w_prod >> 16);

endmodule

@@ src/paged_mmu_random_replacement_top.sv @@
// ----------------------------------------------------------------------------
// Paged MMU with random replacement
// A hit, an illegal address or a fault served from a free frame is answered
// from S_LOOK; a fault that evicts a frame passes S_VSEL, S_OWNER, S_VPTE
// and S_FILL first. S_HOLD keeps a finished response while the output slot
// is full; the next request is taken once the response is registered.
// After reset a clearing pass writes all MAX_PAGES page table entries, one a
// cycle, before the first request is accepted.
// ----------------------------------------------------------------------------
module paged_mmu_random_replacement_top #(
    parameter int MAX_PAGES  = 256,
    parameter int MAX_FRAMES = 64,
    parameter int VADDR_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  pmmu_pkg::t_req                 i_req,
    output logic                           o_rsp_valid,
    input  logic                           i_rsp_ready,
    output pmmu_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pmmu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pmmu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PW    = $clog2(MAX_PAGES);
    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int UW    = $clog2(MAX_FRAMES + 1);
    localparam int PTE_W = FW + 2;
    localparam logic [31:0] VMASK = 32'((64'd1 << VADDR_BITS) - 64'd1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_LOOK  = 8'b0000_0100,
        S_VSEL  = 8'b0000_1000,
        S_OWNER = 8'b0001_0000,
        S_VPTE  = 8'b0010_0000,
        S_FILL  = 8'b0100_0000,
        S_HOLD  = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    logic [4:0]      r_page_shift;
    logic [8:0]      r_num_pages;
    logic [6:0]      r_num_frames;
    logic [UW-1:0]   r_frames_used, n_frames_used;
    logic [PW-1:0]   r_clr_idx;
    logic            r_op;
    logic [PW-1:0]   r_page;
    logic [31:0]     r_offset;
    logic            r_illegal;
    logic [FW-1:0]   r_frame;
    logic [PW-1:0]   r_victim;
    logic            r_wb;
    pmmu_pkg::t_rsp  r_res;
    pmmu_pkg::t_rsp  r_out;
    logic            r_out_valid;

    logic [31:0]     w_vaddr, w_page32, w_offset, w_eff_pages, w_nf32;
    logic [6:0]      w_nf;
    logic            w_accept, w_slot_free, w_finish, w_free, w_step;
    logic [FW-1:0]   w_sel_frame, w_vframe;
    pmmu_pkg::t_rsp  w_res;
    pmmu_pkg::t_victim_ctl w_vctl;

    logic             pt_we;
    logic [PW-1:0]    pt_waddr, pt_raddr;
    logic [PTE_W-1:0] pt_wdata, pt_rdata;
    logic             own_we;
    logic [FW-1:0]    own_waddr;
    logic [PW-1:0]    own_wdata, own_rdata;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_slot_free = !r_out_valid || i_rsp_ready;

    assign w_vaddr     = i_req.vaddr & VMASK;
    assign w_page32    = w_vaddr >> r_page_shift;
    assign w_offset    = w_vaddr & ~(32'hFFFF_FFFF << r_page_shift);
    assign w_eff_pages = (32'(r_num_pages) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                             : 32'(r_num_pages);
    assign w_nf32      = (32'(r_num_frames) > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES)
                                                               : 32'(r_num_frames);
    assign w_nf        = (w_nf32 == 32'd0) ? 7'd1 : 7'(w_nf32);
    assign w_free      = 32'(r_frames_used) < 32'(w_nf);

    assign pt_raddr = (r_state == S_OWNER) ? own_rdata : w_page32[PW-1:0];

    assign w_vctl = '{load:       i_cfg_we && (i_cfg_idx == pmmu_pkg::CFG_RANDOM_SEED),
                      seed:       i_cfg_data,
                      step:       w_step,
                      num_frames: w_nf};

    always_comb begin
        n_state       = r_state;
        n_frames_used = r_frames_used;
        pt_we         = 1'b0;
        pt_waddr      = r_page;
        pt_wdata      = '0;
        own_we        = 1'b0;
        own_waddr     = r_frame;
        own_wdata     = r_page;
        w_step        = 1'b0;
        w_finish      = 1'b0;
        w_sel_frame   = r_frame;
        w_res         = '0;
        unique case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = r_clr_idx;
                if (r_clr_idx == PW'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_illegal) begin
                    w_finish        = 1'b1;
                    w_res.phys_addr = 32'hFFFF_FFFF;
                    w_res.illegal   = 1'b1;
                end else if (pt_rdata[PTE_W-1]) begin
                    w_sel_frame = pt_rdata[FW-1:0];
                    pt_we       = 1'b1;
                    pt_wdata    = {1'b1, pt_rdata[FW] | r_op, w_sel_frame};
                    w_finish    = 1'b1;
                end else if (w_free) begin
                    w_sel_frame      = r_frames_used[FW-1:0];
                    pt_we            = 1'b1;
                    pt_wdata         = {1'b1, r_op, w_sel_frame};
                    own_we           = 1'b1;
                    own_waddr        = w_sel_frame;
                    n_frames_used    = r_frames_used + UW'(1);
                    w_finish         = 1'b1;
                    w_res.pg_fault   = 1'b1;
                end else begin
                    w_step  = 1'b1;
                    n_state = S_VSEL;
                end
            end
            S_VSEL: begin
                n_state = S_OWNER;
            end
            S_OWNER: begin
                n_state = S_VPTE;
            end
            S_VPTE: begin
                pt_we    = 1'b1;
                pt_waddr = r_victim;
                n_state  = S_FILL;
            end
            S_FILL: begin
                pt_we               = 1'b1;
                pt_wdata            = {1'b1, r_op, r_frame};
                own_we              = 1'b1;
                w_finish            = 1'b1;
                w_res.pg_fault      = 1'b1;
                w_res.write_back    = r_wb;
                w_res.evicted_valid = 1'b1;
                w_res.evicted_page  = 8'(r_victim);
            end
            S_HOLD: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_finish && !r_illegal) begin
            w_res.phys_addr = (32'(w_sel_frame) << r_page_shift) + r_offset;
        end
        if (w_finish) begin
            n_state = w_slot_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_frames_used <= '0;
            r_out_valid   <= 1'b0;
            r_page_shift  <= pmmu_pkg::RST_PAGE_SHIFT;
            r_num_pages   <= pmmu_pkg::RST_NUM_PAGES;
            r_num_frames  <= pmmu_pkg::RST_NUM_FRAMES;
        end else begin
            r_state       <= n_state;
            r_clr_idx     <= r_clr_idx + PW'(1);
            r_frames_used <= n_frames_used;
            if ((w_finish || (r_state == S_HOLD)) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pmmu_pkg::CFG_PAGE_SHIFT:  r_page_shift <= i_cfg_data[4:0];
                    pmmu_pkg::CFG_NUM_PAGES:   r_num_pages  <= i_cfg_data[8:0];
                    pmmu_pkg::CFG_NUM_FRAMES:  r_num_frames <= i_cfg_data[6:0];
                    pmmu_pkg::CFG_RANDOM_SEED: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_req.op;
            r_page    <= w_page32[PW-1:0];
            r_offset  <= w_offset;
            r_illegal <= !(w_page32 < w_eff_pages);
        end
        if (r_state == S_VSEL) begin
            r_frame <= w_vframe;
        end
        if (r_state == S_OWNER) begin
            r_victim <= own_rdata;
        end
        if (r_state == S_VPTE) begin
            r_wb <= pt_rdata[FW];
        end
        if (w_finish && !w_slot_free) begin
            r_res <= w_res;
        end
        if (w_finish && w_slot_free) begin
            r_out <= w_res;
        end else if ((r_state == S_HOLD) && w_slot_free) begin
            r_out <= r_res;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    pmmu_victim #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_victim (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_vctl),
        .o_frame(w_vframe)
    );

    pmmu_ram #(
        .WIDTH(PTE_W),
        .DEPTH(MAX_PAGES)
    ) u_page_table (
        .i_clk  (i_clk),
        .i_we   (pt_we),
        .i_waddr(pt_waddr),
        .i_wdata(pt_wdata),
        .i_raddr(pt_raddr),
        .o_rdata(pt_rdata)
    );

    pmmu_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_FRAMES)
    ) u_frame_owner (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(own_waddr),
        .i_wdata(own_wdata),
        .i_raddr(w_vframe),
        .o_rdata(own_rdata)
    );

    a_illegal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.illegal |->
            (o_rsp.phys_addr == 32'hFFFF_FFFF) && !o_rsp.pg_fault && !o_rsp.evicted_valid)
        else $error("Illegal response carries a translation or a fault.");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.write_back |-> o_rsp.evicted_valid && o_rsp.pg_fault)
        else $error("Write-back flagged without an eviction.");

    a_frames_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_frames_used) <= 32'(MAX_FRAMES))
        else $error("Frame allocation count overran the frame table.");

    a_evict_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VSEL) |-> !w_free)
        else $error("Eviction started while a free frame remained.");

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_LOOK))
        else $error("Accepted request did not start a lookup.");

endmodule
